@@ src/chm_pkg.sv @@
package chm_pkg;

  localparam int FieldWords = 4;
  localparam logic [31:0] HashSeed  = 32'h811C9DC5;
  localparam logic [31:0] HashMul   = 32'h9E3779B1;
  localparam logic [31:0] FinalMul  = 32'h85EBCA6B;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    FUNC_LOOKUP = 1'b0,
    FUNC_INSERT = 1'b1
  } func_t;

  typedef enum logic [0:0] {
    REG_KEY_WORDS   = 1'b0,
    REG_VALUE_WORDS = 1'b1
  } reg_idx_t;

  // IEEE single equality: signed zeros equal, NaN never equal
  function automatic logic single_equal(input logic [31:0] a, input logic [31:0] b);
    logic r;
    begin
      if (((a | b) & 32'h7FFFFFFF) == 32'd0) r = 1'b1;
      else if ((a & 32'h7FFFFFFF) > 32'h7F800000) r = 1'b0;
      else r = (a == b);
      return r;
    end
  endfunction

endpackage

@@ src/chained_hash_map.sv @@
// Each request hashes the nk key words in use, reads its bucket head and then each
// chain entry visited, plus a value read for a lookup hit or a relink for a tail append.
// Throughput: one request at a time; the next is taken in the cycle after the result
// leaves. The chain walk through the entry RAM (one read per entry) sets the rate.
// Reset: synchronous, active low. After reset a clearing pass writes every bucket
// head empty, during which in_stall stays high.
module chained_hash_map #(
  parameter int BUCKET_BITS = 10,
  parameter int ENTRY_BITS  = 10,
  parameter int KEY_WORDS   = 4,
  parameter int VALUE_WORDS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_key_word0,
  input  logic [31:0] in_key_word1,
  input  logic [31:0] in_key_word2,
  input  logic [31:0] in_key_word3,
  input  logic [31:0] in_value_word0,
  input  logic [31:0] in_value_word1,
  input  logic [31:0] in_value_word2,
  input  logic [31:0] in_value_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_value0,
  output logic [31:0] out_value1,
  output logic [31:0] out_value2,
  output logic [31:0] out_value3,
  output logic [10:0] out_stored_count
);

  localparam int NB   = 1 << BUCKET_BITS;
  localparam int NE   = 1 << ENTRY_BITS;
  localparam int KW   = (KEY_WORDS < chm_pkg::FieldWords) ? KEY_WORDS : chm_pkg::FieldWords;
  localparam int VW   = (VALUE_WORDS < chm_pkg::FieldWords) ? VALUE_WORDS : chm_pkg::FieldWords;
  localparam int HW   = ENTRY_BITS + 1;
  localparam int EW   = 32 * KW + ENTRY_BITS + 1;
  localparam int VRW  = 32 * VW;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HASH  = 9'b000000100,
    S_HEAD  = 9'b000001000,
    S_HEADW = 9'b000010000,
    S_ENT   = 9'b000100000,
    S_ENTW  = 9'b001000000,
    S_VAL   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t st_r, st_nxt;

  logic [2:0] kreg_r, vreg_r;
  logic [2:0] nk, nv;

  always_comb begin
    nk = (kreg_r == 3'd0) ? 3'd1 : ((kreg_r > 3'(KW)) ? 3'(KW) : kreg_r);
    nv = (vreg_r == 3'd0) ? 3'd1 : ((vreg_r > 3'(VW)) ? 3'(VW) : vreg_r);
  end

  logic                   func_r;
  logic [31:0]            key_r [chm_pkg::FieldWords];
  logic [31:0]            val_r [chm_pkg::FieldWords];
  logic [BUCKET_BITS-1:0] clr_r, clr_nxt;
  logic [BUCKET_BITS-1:0] bkt_r, bkt_nxt;
  logic [ENTRY_BITS-1:0]  idx_r, idx_nxt;
  logic [ENTRY_BITS:0]    cnt_r, cnt_nxt;
  logic [2:0]             status_r, status_nxt;
  logic [VRW-1:0]         oval_r, oval_nxt;

  logic hash_done;
  logic [BUCKET_BITS-1:0] hash_bucket;

  chm_hash #(.BUCKET_BITS(BUCKET_BITS)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(st_r == S_IDLE && in_valid),
    .key(key_r), .nk(nk), .done(hash_done), .bucket(hash_bucket)
  );

  // bucket head RAM: {valid, index}
  logic                   h_we;
  logic [BUCKET_BITS-1:0] h_waddr, h_raddr;
  logic [HW-1:0]          h_wdata, h_rdata;

  chm_ram #(.WIDTH(HW), .DEPTH(NB)) u_heads (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  // entry RAM: {link valid, link, key words}
  logic                  e_we;
  logic [ENTRY_BITS-1:0] e_waddr, e_raddr;
  logic [EW-1:0]         e_wdata, e_rdata;

  chm_ram #(.WIDTH(EW), .DEPTH(NE)) u_entries (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  logic                  v_we;
  logic [ENTRY_BITS-1:0] v_waddr, v_raddr;
  logic [VRW-1:0]        v_wdata, v_rdata;

  chm_ram #(.WIDTH(VRW), .DEPTH(NE)) u_values (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  logic match;
  logic [VRW-1:0] newval;
  logic [32*KW-1:0] newkey;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < KW; i++) begin
      if (3'(i) < nk && !chm_pkg::single_equal(e_rdata[32*i +: 32], key_r[i])) match = 1'b0;
    end
    for (int i = 0; i < VW; i++) newval[32*i +: 32] = (3'(i) < nv) ? val_r[i] : 32'd0;
    for (int i = 0; i < KW; i++) newkey[32*i +: 32] = (3'(i) < nk) ? key_r[i] : 32'd0;
  end

  logic full;
  assign full = cnt_r[ENTRY_BITS];

  // tail key kept for the relink write
  logic [32*KW-1:0] tailkey_r;

  always_comb begin
    st_nxt     = st_r;
    clr_nxt    = clr_r;
    bkt_nxt    = bkt_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    oval_nxt   = oval_r;
    h_we = 1'b0; h_waddr = clr_r; h_wdata = '0; h_raddr = hash_bucket;
    e_we = 1'b0; e_waddr = cnt_r[ENTRY_BITS-1:0]; e_wdata = '0; e_raddr = idx_r;
    v_we = 1'b0; v_waddr = idx_r; v_wdata = newval; v_raddr = idx_r;
    case (st_r)
      S_CLEAR: begin
        h_we    = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BUCKET_BITS'(NB - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) st_nxt = S_HASH;
      end
      S_HASH: begin
        if (hash_done) begin
          bkt_nxt = hash_bucket;
          st_nxt  = S_HEAD;
        end
      end
      S_HEAD: st_nxt = S_HEADW;
      S_HEADW: begin
        if (h_rdata[ENTRY_BITS]) begin
          idx_nxt = h_rdata[ENTRY_BITS-1:0];
          st_nxt  = S_ENT;
        end else if (func_r == chm_pkg::FUNC_LOOKUP) begin
          status_nxt = chm_pkg::ST_MISS;
          oval_nxt   = '0;
          st_nxt     = S_OUT;
        end else if (full) begin
          status_nxt = chm_pkg::ST_FULL;
          oval_nxt   = '0;
          st_nxt     = S_OUT;
        end else begin
          h_we    = 1'b1;
          h_waddr = bkt_r;
          h_wdata = {1'b1, cnt_r[ENTRY_BITS-1:0]};
          e_we    = 1'b1;
          e_wdata = {1'b0, {ENTRY_BITS{1'b0}}, newkey};
          v_we    = 1'b1;
          v_waddr = cnt_r[ENTRY_BITS-1:0];
          cnt_nxt = cnt_r + 1'b1;
          status_nxt = chm_pkg::ST_INSERTED;
          oval_nxt   = '0;
          st_nxt     = S_OUT;
        end
      end
      S_ENT: st_nxt = S_ENTW;
      S_ENTW: begin
        if (match) begin
          if (func_r == chm_pkg::FUNC_LOOKUP) begin
            st_nxt = S_VAL;
          end else begin
            v_we       = 1'b1;
            status_nxt = chm_pkg::ST_UPDATED;
            oval_nxt   = '0;
            st_nxt     = S_OUT;
          end
        end else if (e_rdata[EW-1]) begin
          idx_nxt = e_rdata[EW-2 -: ENTRY_BITS];
          st_nxt  = S_ENT;
        end else if (func_r == chm_pkg::FUNC_LOOKUP) begin
          status_nxt = chm_pkg::ST_MISS;
          oval_nxt   = '0;
          st_nxt     = S_OUT;
        end else if (full) begin
          status_nxt = chm_pkg::ST_FULL;
          oval_nxt   = '0;
          st_nxt     = S_OUT;
        end else begin
          // append: new entry, then relink the tail (second write next cycle)
          e_we    = 1'b1;
          e_wdata = {1'b0, {ENTRY_BITS{1'b0}}, newkey};
          v_we    = 1'b1;
          v_waddr = cnt_r[ENTRY_BITS-1:0];
          status_nxt = chm_pkg::ST_INSERTED;
          oval_nxt   = '0;
          st_nxt     = S_VAL;
        end
      end
      S_VAL: begin
        if (status_r == chm_pkg::ST_INSERTED && func_r == chm_pkg::FUNC_INSERT) begin
          e_we    = 1'b1;
          e_waddr = idx_r;
          e_wdata = {1'b1, cnt_r[ENTRY_BITS-1:0], tailkey_r};
          cnt_nxt = cnt_r + 1'b1;
          oval_nxt = '0;
          st_nxt  = S_OUT;
        end else begin
          st_nxt = S_OUT;
          status_nxt = chm_pkg::ST_HIT;
          for (int i = 0; i < VW; i++)
            oval_nxt[32*i +: 32] = (3'(i) < nv) ? v_rdata[32*i +: 32] : 32'd0;
        end
      end
      S_OUT: begin
        if (!out_stall) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLEAR;
      clr_r  <= '0;
      cnt_r  <= '0;
      kreg_r <= 3'd4;
      vreg_r <= 3'd4;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we && cfg_index == chm_pkg::REG_KEY_WORDS) kreg_r <= cfg_wdata;
      if (cfg_we && cfg_index == chm_pkg::REG_VALUE_WORDS) vreg_r <= cfg_wdata;
    end
    bkt_r    <= bkt_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    oval_r   <= oval_nxt;
    if (st_r == S_ENTW) tailkey_r <= e_rdata[32*KW-1:0];
    if (st_r == S_IDLE && in_valid) begin
      func_r   <= in_func;
      key_r[0] <= in_key_word0; key_r[1] <= in_key_word1;
      key_r[2] <= in_key_word2; key_r[3] <= in_key_word3;
      val_r[0] <= in_value_word0; val_r[1] <= in_value_word1;
      val_r[2] <= in_value_word2; val_r[3] <= in_value_word3;
    end
  end

  assign in_stall         = (st_r != S_IDLE);
  assign out_valid        = (st_r == S_OUT);
  assign out_status       = status_r;
  assign out_value0       = oval_r[31:0];
  assign out_value1       = (VW > 1) ? oval_r[32*((VW > 1) ? 1 : 0) +: 32] : 32'd0;
  assign out_value2       = (VW > 2) ? oval_r[32*((VW > 2) ? 2 : 0) +: 32] : 32'd0;
  assign out_value3       = (VW > 3) ? oval_r[32*((VW > 3) ? 3 : 0) +: 32] : 32'd0;
  assign out_stored_count = 11'(cnt_r);

endmodule

@@ src/chm_ram.sv @@
module chm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/chm_hash.sv @@
// Iterative key mix: one round per cycle, one 32x32 multiply per round.
module chm_hash #(
  parameter int BUCKET_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [31:0]            key [chm_pkg::FieldWords],
  input  logic [2:0]             nk,
  output logic                   done,
  output logic [BUCKET_BITS-1:0] bucket
);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MIX  = 4'b0010,
    H_FIN  = 4'b0100,
    H_DONE = 4'b1000
  } hstate_t;

  hstate_t     st_r, st_nxt;
  logic [31:0] h_r, h_nxt;
  logic [2:0]  i_r, i_nxt;
  logic [31:0] t;
  logic [63:0] p;

  always_comb begin
    st_nxt = st_r;
    h_nxt  = h_r;
    i_nxt  = i_r;
    t      = 32'd0;
    p      = 64'd0;
    case (st_r)
      H_IDLE: begin
        if (start) begin
          h_nxt  = chm_pkg::HashSeed;
          i_nxt  = 3'd0;
          st_nxt = H_MIX;
        end
      end
      H_MIX: begin
        t     = h_r ^ key[i_r[1:0]];
        p     = {32'd0, t} * {32'd0, chm_pkg::HashMul};
        h_nxt = p[31:0] ^ {16'd0, p[31:16]};
        i_nxt = i_r + 3'd1;
        if (i_nxt >= nk) st_nxt = H_FIN;
      end
      H_FIN: begin
        t      = h_r ^ {13'd0, h_r[31:13]};
        p      = {32'd0, t} * {32'd0, chm_pkg::FinalMul};
        h_nxt  = p[31:0] ^ {16'd0, p[31:16]};
        st_nxt = H_DONE;
      end
      H_DONE: st_nxt = H_IDLE;
      default: st_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= H_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    h_r <= h_nxt;
    i_r <= i_nxt;
  end

  assign done   = (st_r == H_DONE);
  assign bucket = h_r[BUCKET_BITS-1:0];

endmodule

@@ src/chm_checker.sv @@
module chm_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_value0,
  input logic [10:0] out_stored_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while result pending");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= chm_pkg::ST_FULL)
    else $error("bad status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != chm_pkg::ST_HIT |-> out_value0 == 32'd0)
    else $error("value on non-hit");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stored_count <= 11'd1024)
    else $error("stored count out of range");

endmodule

bind chained_hash_map chm_props u_chm_props (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_value0(out_value0), .out_stored_count(out_stored_count)
);
